// File: rtl/wfc_pkg.sv
`timescale 1ns / 1ps

package wfc_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int WORD_BYTES_DEF    = 4;
  localparam int COUNT_BITS_DEF    = 32;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_EOL   = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] text_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] word_value;
    logic [31:0] word_count;
    logic        found;
    logic        word_dropped;
  } out_rsp_t;

endpackage

// File: rtl/wfc_table.sv
`timescale 1ns / 1ps

module wfc_table #(
  parameter int DEPTH  = wfc_pkg::TABLE_ENTRIES_DEF,
  parameter int DATA_W = 1 + wfc_pkg::COUNT_BITS_DEF + 8 * wfc_pkg::WORD_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/wfc_chunk.sv
`timescale 1ns / 1ps

module wfc_chunk #(
  parameter int WORD_BYTES = wfc_pkg::WORD_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    byte_en,
  input  logic                    clear_en,
  input  logic [7:0]              text_byte,
  output logic                    word_done,
  output logic [8*WORD_BYTES-1:0] word
);

  localparam int FILL_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [8*WORD_BYTES-1:0] chunk_r, chunk_nxt;
  logic [7:0]              folded;

  assign folded = (text_byte >= wfc_pkg::CHAR_ZERO && text_byte <= wfc_pkg::CHAR_NINE) ?
                  wfc_pkg::CHAR_ZERO : text_byte;

  always_comb begin
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (fill_r == FILL_W'(k)) begin
        word[8*k +: 8] = folded;
      end else if (fill_r > FILL_W'(k)) begin
        word[8*k +: 8] = chunk_r[8*k +: 8];
      end else begin
        word[8*k +: 8] = 8'h00;
      end
    end
  end

  assign word_done = (fill_r == FILL_W'(WORD_BYTES - 1));

  always_comb begin
    fill_nxt  = fill_r;
    chunk_nxt = chunk_r;
    if (clear_en) begin
      fill_nxt = '0;
    end else if (byte_en) begin
      if (word_done) begin
        fill_nxt = '0;
      end else begin
        fill_nxt  = fill_r + FILL_W'(1);
        chunk_nxt = word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
    chunk_r <= chunk_nxt;
  end

endmodule

// File: rtl/wfc_ctrl.sv
`timescale 1ns / 1ps

module wfc_ctrl #(
  parameter int TABLE_ENTRIES = wfc_pkg::TABLE_ENTRIES_DEF,
  parameter int WORD_BYTES    = wfc_pkg::WORD_BYTES_DEF,
  parameter int COUNT_BITS    = wfc_pkg::COUNT_BITS_DEF,
  localparam int IDX_W        = $clog2(TABLE_ENTRIES),
  localparam int WORD_W       = 8 * WORD_BYTES,
  localparam int ENTRY_W      = 1 + COUNT_BITS + WORD_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  wfc_pkg::in_req_t   in_req,
  output logic               busy,
  input  logic               word_done,
  input  logic [WORD_W-1:0]  word,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [ENTRY_W-1:0] rd_data,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [ENTRY_W-1:0] wr_data,
  output logic               out_strobe,
  output wfc_pkg::out_rsp_t  out_rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  localparam logic [IDX_W:0] USED_FULL = (IDX_W + 1)'(TABLE_ENTRIES);

  logic                  state_r, state_nxt;
  logic                  mode_r, mode_nxt;
  logic [IDX_W:0]        used_r, used_nxt;
  logic [IDX_W:0]        iss_r, iss_nxt;
  logic                  dv_r, dv_nxt;
  logic [IDX_W-1:0]      di_r, di_nxt;
  logic [WORD_W-1:0]     key_r, key_nxt;
  logic                  have_r, have_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [WORD_W-1:0]     best_word_r, best_word_nxt;
  logic [COUNT_BITS-1:0] best_cnt_r, best_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  wfc_pkg::out_rsp_t     out_rsp_r, out_rsp_nxt;

  logic                  accept;
  logic [WORD_W-1:0]     rd_word;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_rep;
  logic [COUNT_BITS-1:0] rd_cnt_inc;
  logic                  more;
  logic [31:0]           word32;
  logic [31:0]           cnt32;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign rd_word    = rd_data[WORD_W-1:0];
  assign rd_cnt     = rd_data[WORD_W +: COUNT_BITS];
  assign rd_rep     = rd_data[ENTRY_W-1];
  assign rd_cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign more       = (iss_r < used_r);
  assign rd_addr    = iss_r[IDX_W-1:0];

  generate
    if (WORD_W >= 32) begin : g_word_trunc
      assign word32 = best_word_r[31:0];
    end else begin : g_word_ext
      assign word32 = {{(32 - WORD_W){1'b0}}, best_word_r};
    end
    if (COUNT_BITS > 32) begin : g_cnt_sat
      assign cnt32 = (|best_cnt_r[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : best_cnt_r[31:0];
    end else if (COUNT_BITS == 32) begin : g_cnt_same
      assign cnt32 = best_cnt_r;
    end else begin : g_cnt_ext
      assign cnt32 = {{(32 - COUNT_BITS){1'b0}}, best_cnt_r};
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    used_nxt      = used_r;
    iss_nxt       = iss_r;
    dv_nxt        = dv_r;
    di_nxt        = di_r;
    key_nxt       = key_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_word_nxt = best_word_r;
    best_cnt_nxt  = best_cnt_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = '0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = di_r;
    wr_data       = {rd_rep, rd_cnt_inc, rd_word};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          iss_nxt  = '0;
          dv_nxt   = 1'b0;
          have_nxt = 1'b0;
          if (in_req.operation == wfc_pkg::OP_BYTE && word_done) begin
            state_nxt = ST_SCAN;
            mode_nxt  = MODE_STORE;
            key_nxt   = word;
          end else if (in_req.operation == wfc_pkg::OP_FETCH) begin
            state_nxt = ST_SCAN;
            mode_nxt  = MODE_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (more) begin
          rd_en   = 1'b1;
          iss_nxt = iss_r + (IDX_W + 1)'(1);
          dv_nxt  = 1'b1;
          di_nxt  = iss_r[IDX_W-1:0];
        end else begin
          dv_nxt = 1'b0;
        end

        if (dv_r && mode_r == MODE_STORE && rd_word == key_r) begin
          wr_en         = 1'b1;
          state_nxt     = ST_IDLE;
          dv_nxt        = 1'b0;
          out_valid_nxt = 1'b1;
        end else if (dv_r && mode_r == MODE_FETCH) begin
          if (!rd_rep && (!have_r || rd_cnt > best_cnt_r)) begin
            have_nxt      = 1'b1;
            best_idx_nxt  = di_r;
            best_word_nxt = rd_word;
            best_cnt_nxt  = rd_cnt;
          end
        end else if (!dv_r && !more) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (mode_r == MODE_STORE) begin
            if (used_r >= USED_FULL) begin
              out_rsp_nxt.word_dropped = 1'b1;
            end else begin
              wr_en    = 1'b1;
              wr_addr  = used_r[IDX_W-1:0];
              wr_data  = {1'b0, COUNT_BITS'(1), key_r};
              used_nxt = used_r + (IDX_W + 1)'(1);
            end
          end else if (have_r) begin
            wr_en                  = 1'b1;
            wr_addr                = best_idx_r;
            wr_data                = {1'b1, best_cnt_r, best_word_r};
            out_rsp_nxt.word_value = word32;
            out_rsp_nxt.word_count = cnt32;
            out_rsp_nxt.found      = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      iss_r       <= '0;
      dv_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r      <= mode_nxt;
    di_r        <= di_nxt;
    key_r       <= key_nxt;
    best_idx_r  <= best_idx_nxt;
    best_word_r <= best_word_nxt;
    best_cnt_r  <= best_cnt_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_rsp    = out_rsp_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_FULL)
    else $error("table fill count beyond capacity");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r <= used_r || state_r == ST_IDLE)
    else $error("scan issued past filled entries");

  a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> state_r == ST_SCAN)
    else $error("read data pending outside scan");

  a_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> state_r == ST_IDLE && out_valid_r)
    else $error("table write without closing the request");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_IDLE) |=> out_valid_r && !busy)
    else $error("scan finished without a result");
`endif

endmodule

// File: rtl/word_frequency_counter_top.sv
`timescale 1ns / 1ps

// Word frequency counter. A request is taken when start is high and busy is
// low; every request yields exactly one result on out_rsp, marked by a
// one-cycle out_strobe that the receiver cannot hold off. A text byte that
// does not complete a word, an end-of-line mark, or an unused code returns its
// result in the next cycle with busy left low, so such requests may come every
// cycle. A byte that completes a word, and a fetch, scan the table through its
// single read port, one filled entry per cycle: busy stays high while it reads
// up to N filled entries (N at most TABLE_ENTRIES), and the result appears in
// the cycle busy falls. A repeated word ends its scan at its match.
module word_frequency_counter_top #(
  parameter int TABLE_ENTRIES = wfc_pkg::TABLE_ENTRIES_DEF,
  parameter int WORD_BYTES    = wfc_pkg::WORD_BYTES_DEF,
  parameter int COUNT_BITS    = wfc_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  wfc_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output wfc_pkg::out_rsp_t out_rsp
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int WORD_W  = 8 * WORD_BYTES;
  localparam int ENTRY_W = 1 + COUNT_BITS + WORD_W;

  logic               accept;
  logic               byte_en;
  logic               clear_en;
  logic               word_done;
  logic [WORD_W-1:0]  word;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  assign accept   = start && !busy;
  assign byte_en  = accept && (in_req.operation == wfc_pkg::OP_BYTE);
  assign clear_en = accept && (in_req.operation == wfc_pkg::OP_EOL);

  wfc_chunk #(
    .WORD_BYTES(WORD_BYTES)
  ) u_chunk (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (byte_en),
    .clear_en (clear_en),
    .text_byte(in_req.text_byte),
    .word_done(word_done),
    .word     (word)
  );

  wfc_table #(
    .DEPTH (TABLE_ENTRIES),
    .DATA_W(ENTRY_W)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  wfc_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .WORD_BYTES   (WORD_BYTES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .word_done (word_done),
    .word      (word),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp)
  );

endmodule

// File: bench/tb_word_frequency_counter_top.sv
`timescale 1ns / 1ps

module tb_word_frequency_counter_top;
  import wfc_pkg::*;

  localparam int TBL_DEPTH     = TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = TABLE_ENTRIES_DEF + 40;
  localparam int VOCAB_SIZE    = 24;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [7:0] CHAR_A    = 8'h61;

  typedef struct packed {
    in_req_t  req;
    out_rsp_t rsp;
  } step_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_strobe;
  out_rsp_t out_rsp;

  logic [31:0] slot_word [TBL_DEPTH];
  logic [31:0] slot_count [TBL_DEPTH];
  bit          slot_reported [TBL_DEPTH];
  int          slots_used = 0;
  logic [31:0] chunk = '0;
  int          chunk_len = 0;

  logic [7:0] vocab [VOCAB_SIZE][WORD_BYTES_DEF];
  step_row_t  steps [$];
  out_rsp_t   pending_rsp [$];
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         idle_pct = 0;

  word_frequency_counter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  always #10 clk = ~clk;

  function automatic out_rsp_t tally_request(in_req_t r);
    out_rsp_t   rsp;
    logic [7:0] b;
    int         hit;
    int         best;
    rsp = '0;
    case (r.operation)
      OP_BYTE: begin
        b = (r.text_byte >= CHAR_ZERO && r.text_byte <= CHAR_NINE) ? CHAR_ZERO : r.text_byte;
        chunk = chunk | (32'(b) << (8 * chunk_len));
        chunk_len++;
        if (chunk_len == WORD_BYTES_DEF) begin
          hit = -1;
          for (int i = 0; i < slots_used; i++)
            if (slot_word[i] == chunk) hit = i;
          if (hit >= 0) begin
            if (slot_count[hit] != '1) slot_count[hit] = slot_count[hit] + 1;
          end else if (slots_used >= TBL_DEPTH) begin
            rsp.word_dropped = 1'b1;
          end else begin
            slot_word[slots_used] = chunk;
            slot_count[slots_used] = 32'd1;
            slot_reported[slots_used] = 1'b0;
            slots_used++;
          end
          chunk = '0;
          chunk_len = 0;
        end
      end
      OP_EOL: begin
        chunk = '0;
        chunk_len = 0;
      end
      OP_FETCH: begin
        best = -1;
        for (int i = 0; i < slots_used; i++)
          if (!slot_reported[i] && (best < 0 || slot_count[i] > slot_count[best])) best = i;
        if (best >= 0) begin
          slot_reported[best] = 1'b1;
          rsp.word_value = slot_word[best];
          rsp.word_count = slot_count[best];
          rsp.found = 1'b1;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void add_step(logic [1:0] op, logic [7:0] b, logic [31:0] w,
                                   logic [31:0] c, logic f);
    step_row_t s;
    s.req.operation = op;
    s.req.text_byte = b;
    s.rsp.word_value = w;
    s.rsp.word_count = c;
    s.rsp.found = f;
    s.rsp.word_dropped = 1'b0;
    steps.push_back(s);
  endfunction

  task automatic issue(in_req_t r, bit typed, out_rsp_t typed_rsp);
    out_rsp_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = tally_request(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic send_mix(int n);
    in_req_t    r;
    int         sent;
    int         kind;
    int         pick;
    int         cut;
    logic [7:0] b;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      r.text_byte = 8'($urandom);
      if (kind < 60) begin
        pick = $urandom_range(VOCAB_SIZE + 9);
        cut = ($urandom_range(99) < 8) ? $urandom_range(1, WORD_BYTES_DEF - 1) : WORD_BYTES_DEF;
        for (int k = 0; k < cut; k++) begin
          if (pick < VOCAB_SIZE) begin
            b = vocab[pick][k];
            if (b >= CHAR_ZERO && b <= CHAR_NINE) b = CHAR_ZERO + 8'($urandom_range(9));
          end else begin
            b = 8'($urandom);
          end
          r.operation = OP_BYTE;
          r.text_byte = b;
          issue(r, 1'b0, '0);
          sent++;
        end
        if (cut < WORD_BYTES_DEF) begin
          r.operation = OP_EOL;
          r.text_byte = 8'($urandom);
          issue(r, 1'b0, '0);
          sent++;
        end
      end else begin
        if (kind < 75) r.operation = OP_FETCH;
        else if (kind < 84) r.operation = OP_EOL;
        else if (kind < 90) r.operation = OP_UNUSED;
        else r.operation = OP_BYTE;
        issue(r, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic flood_new_words();
    in_req_t r;
    r.operation = OP_BYTE;
    while (slots_used < TBL_DEPTH) begin
      for (int k = 0; k < WORD_BYTES_DEF; k++) begin
        r.text_byte = {1'b1, 7'($urandom_range(127))};
        issue(r, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_strobe) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_rsp);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.word_value !== want.word_value) begin
          $display("%0t: word_value expected %h actual %h", $time, want.word_value,
                   out_rsp.word_value);
          mismatch_count++;
        end
        if (out_rsp.word_count !== want.word_count) begin
          $display("%0t: word_count expected %0d actual %0d", $time, want.word_count,
                   out_rsp.word_count);
          mismatch_count++;
        end
        if (out_rsp.found !== want.found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, out_rsp.found);
          mismatch_count++;
        end
        if (out_rsp.word_dropped !== want.word_dropped) begin
          $display("%0t: word_dropped expected %b actual %b", $time, want.word_dropped,
                   out_rsp.word_dropped);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_word_frequency_counter_top failed");
        $finish;
      end
    end
  end

  initial begin
    for (int w = 0; w < VOCAB_SIZE; w++)
      for (int k = 0; k < WORD_BYTES_DEF; k++)
        vocab[w][k] = ($urandom_range(4) == 0) ? CHAR_ZERO + 8'($urandom_range(9))
                                               : CHAR_A + 8'($urandom_range(25));

    add_step(OP_FETCH,  8'hFF, 32'h0, 32'd0, 1'b0);
    add_step(OP_EOL,    8'h00, 32'h0, 32'd0, 1'b0);
    add_step(OP_UNUSED, 8'hFF, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h31, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h61, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h39, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h7A, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h00, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'hFF, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h2F, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h3A, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h80, 32'h0, 32'd0, 1'b0);
    add_step(OP_EOL,    8'hA5, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h30, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h61, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h35, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h7A, 32'h0, 32'd0, 1'b0);
    add_step(OP_FETCH,  8'h5A, 32'h7A30_6130, 32'd2, 1'b1);
    add_step(OP_FETCH,  8'h00, 32'h3A2F_FF00, 32'd1, 1'b1);
    add_step(OP_FETCH,  8'hFF, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h39, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h61, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h30, 32'h0, 32'd0, 1'b0);
    add_step(OP_BYTE,   8'h7A, 32'h0, 32'd0, 1'b0);
    add_step(OP_FETCH,  8'h0F, 32'h0, 32'd0, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 11;
    foreach (steps[i]) issue(steps[i].req, 1'b1, steps[i].rsp);
    send_mix(150);
    drain_results();

    idle_pct = 85;
    flood_new_words();
    send_mix(100);
    drain_results();

    idle_pct = 0;
    send_mix(150);
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("tb_word_frequency_counter_top passed");
    end else begin
      $display("tb_word_frequency_counter_top failed");
    end
    $finish;
  end

endmodule
